// ----- rtl/rmq_pkg.sv -----
// Shared types, widths and constants for the rotation matrix to quaternion block.
package rmq_pkg;

  localparam int FRAC_BITS = 30;
  localparam int IN_W      = 32;
  localparam int T_W       = IN_W + 2;
  localparam int B_W       = (IN_W + FRAC_BITS) / 2;
  localparam int R_W       = B_W + 1;
  localparam int RAD_W     = 2 * R_W;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int DVD_W     = R_W + FRAC_BITS;
  localparam int SGN_W     = 6;

  localparam logic signed [T_W-1:0] ONE_T = T_W'(64'd1 << FRAC_BITS);
  localparam logic [Q_W-1:0]         ONE_Q = Q_W'(64'd1 << FRAC_BITS);

  // Sign flags of the off-diagonal sums and differences
  localparam int SG_D21_12 = 0;
  localparam int SG_D02_20 = 1;
  localparam int SG_D10_01 = 2;
  localparam int SG_S10_01 = 3;
  localparam int SG_S02_20 = 4;
  localparam int SG_S21_12 = 5;

  typedef struct packed {
    logic signed [IN_W-1:0] m00;
    logic signed [IN_W-1:0] m01;
    logic signed [IN_W-1:0] m02;
    logic signed [IN_W-1:0] m10;
    logic signed [IN_W-1:0] m11;
    logic signed [IN_W-1:0] m12;
    logic signed [IN_W-1:0] m20;
    logic signed [IN_W-1:0] m21;
    logic signed [IN_W-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [IN_W-1:0] quat_w;
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
  } out_t;

endpackage

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
// Usage:
//   in_valid/in_ready/in_data carry one item: a 3x3 matrix, nine signed
//   Q2.30 elements. out_valid/out_ready/out_data return one item per input:
//   the quaternion (w,x,y,z) in Q2.30, normalized to unit length.
//   Throughput: one item per cycle while the output is not stalled. Each
//   item passes through the four-lane magnitude square root, the norm
//   square root and the four-lane divider, each one bit per stage, before
//   out_valid rises for it.
//   Reset (rst_n low, synchronous) empties the pipeline; no item is lost
//   since in_ready stays low while reset is held.
//   Stall: a result waiting in the output register holds; the pipeline
//   still advances while its last stage is empty, so input is taken until
//   a finished item reaches the end, then everything holds together.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  function automatic logic [RAD_W-1:0] to_rad(input logic signed [T_W-1:0] t);
    logic [RAD_W-1:0] r;
    r = '0;
    if (t > 0) r = RAD_W'(t[T_W-2:0]) << (FRAC_BITS - 2);
    return r;
  endfunction

  function automatic logic sgn_of(input logic signed [IN_W-1:0] a,
                                  input logic signed [IN_W-1:0] b,
                                  input logic                   sub);
    logic signed [IN_W:0] s;
    s = sub ? ((IN_W+1)'(a) - (IN_W+1)'(b)) : ((IN_W+1)'(a) + (IN_W+1)'(b));
    return s[IN_W];
  endfunction

  logic en;
  logic load;

  // Stage A: diagonal sums, radicands and sign flags
  logic signed [T_W-1:0] e00, e11, e22;
  logic signed [T_W-1:0] t_a [4];
  logic [RAD_W-1:0]      rad_r [4];
  logic [SGN_W-1:0]      sgn_nxt, sgn_r;
  logic                  va_r;

  assign e00 = T_W'(in_data.m00);
  assign e11 = T_W'(in_data.m11);
  assign e22 = T_W'(in_data.m22);
  assign t_a[0] =  e00 + e11 + e22 + ONE_T;
  assign t_a[1] =  e00 - e11 - e22 + ONE_T;
  assign t_a[2] = -e00 + e11 - e22 + ONE_T;
  assign t_a[3] = -e00 - e11 + e22 + ONE_T;

  always_comb begin
    sgn_nxt = '0;
    sgn_nxt[SG_D21_12] = sgn_of(in_data.m21, in_data.m12, 1'b1);
    sgn_nxt[SG_D02_20] = sgn_of(in_data.m02, in_data.m20, 1'b1);
    sgn_nxt[SG_D10_01] = sgn_of(in_data.m10, in_data.m01, 1'b1);
    sgn_nxt[SG_S10_01] = sgn_of(in_data.m10, in_data.m01, 1'b0);
    sgn_nxt[SG_S02_20] = sgn_of(in_data.m02, in_data.m20, 1'b0);
    sgn_nxt[SG_S21_12] = sgn_of(in_data.m21, in_data.m12, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) rad_r[i] <= to_rad(t_a[i]);
      sgn_r <= sgn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  // Stage B: four magnitude square roots, sign flags and valid follow along
  logic [R_W-1:0]   b_b [4];
  logic [SGN_W-1:0] sgn_b_r [R_W];
  logic             vb_r    [R_W];

  for (genvar i = 0; i < 4; i++) begin : g_mag
    rmq_sqrt u_sqrt (.clk(clk), .en(en), .rad_i(rad_r[i]), .root_o(b_b[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgn_b_r[0] <= sgn_r;
      for (int k = 1; k < R_W; k++) sgn_b_r[k] <= sgn_b_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < R_W; k++) vb_r[k] <= 1'b0;
    end else if (en) begin
      vb_r[0] <= va_r;
      for (int k = 1; k < R_W; k++) vb_r[k] <= vb_r[k-1];
    end
  end

  // Stage C: pick the largest magnitude, resolve signs, square
  logic [1:0]       big;
  logic [R_W-1:0]   mx;
  logic [3:0]       neg_nxt, neg_c_r;
  logic [SGN_W-1:0] sg;
  logic [R_W-1:0]   b_c_r [4];
  logic [RAD_W-1:0] sq_r  [4];
  logic             vc_r;

  assign sg = sgn_b_r[R_W-1];

  always_comb begin
    big = 2'd0;
    mx  = b_b[0];
    for (int i = 1; i < 4; i++) begin
      if (b_b[i] > mx) begin
        big = 2'(i);
        mx  = b_b[i];
      end
    end
  end

  always_comb begin
    neg_nxt = '0;
    unique case (big)
      2'd0: begin
        neg_nxt[1] = sg[SG_D21_12];
        neg_nxt[2] = sg[SG_D02_20];
        neg_nxt[3] = sg[SG_D10_01];
      end
      2'd1: begin
        neg_nxt[0] = sg[SG_D21_12];
        neg_nxt[2] = sg[SG_S10_01];
        neg_nxt[3] = sg[SG_S02_20];
      end
      2'd2: begin
        neg_nxt[0] = sg[SG_D02_20];
        neg_nxt[1] = sg[SG_S10_01];
        neg_nxt[3] = sg[SG_S21_12];
      end
      default: begin
        neg_nxt[0] = sg[SG_D10_01];
        neg_nxt[1] = sg[SG_S02_20];
        neg_nxt[2] = sg[SG_S21_12];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        b_c_r[i] <= b_b[i];
        sq_r[i]  <= RAD_W'(b_b[i]) * RAD_W'(b_b[i]);
      end
      neg_c_r <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r[R_W-1];
    end
  end

  // Stage D: sum of squares
  logic [RAD_W-1:0] sum_r;
  logic [R_W-1:0]   b_d_r [4];
  logic [3:0]       neg_d_r;
  logic             vd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= sq_r[0] + sq_r[1] + sq_r[2] + sq_r[3];
      b_d_r   <= b_c_r;
      neg_d_r <= neg_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  // Stage E: norm square root, magnitudes and signs follow along
  logic [R_W-1:0] nrm;
  logic [R_W-1:0] b_e_r   [R_W][4];
  logic [3:0]     neg_e_r [R_W];
  logic           ve_r    [R_W];

  rmq_sqrt u_norm (.clk(clk), .en(en), .rad_i(sum_r), .root_o(nrm));

  always_ff @(posedge clk) begin
    if (en) begin
      b_e_r[0]   <= b_d_r;
      neg_e_r[0] <= neg_d_r;
      for (int k = 1; k < R_W; k++) begin
        b_e_r[k]   <= b_e_r[k-1];
        neg_e_r[k] <= neg_e_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < R_W; k++) ve_r[k] <= 1'b0;
    end else if (en) begin
      ve_r[0] <= vd_r;
      for (int k = 1; k < R_W; k++) ve_r[k] <= ve_r[k-1];
    end
  end

  // Stage F: dividends with half the divisor added for round to nearest
  logic [DVD_W-1:0] dvd_r [4];
  logic [R_W-1:0]   dvs_r;
  logic [3:0]       neg_f_r;
  logic             vf_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        dvd_r[i] <= (DVD_W'(b_e_r[R_W-1][i]) << FRAC_BITS) + DVD_W'(nrm >> 1);
      end
      dvs_r   <= nrm;
      neg_f_r <= neg_e_r[R_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= ve_r[R_W-1];
    end
  end

  // Stage G: four dividers
  logic [Q_W-1:0] quo [4];
  logic [3:0]     neg_g_r [Q_W];
  logic           vg_r    [Q_W];
  logic           v_last;

  for (genvar i = 0; i < 4; i++) begin : g_div
    rmq_div u_div (
      .clk  (clk),
      .en   (en),
      .dvd_i(dvd_r[i]),
      .dvs_i(dvs_r),
      .quo_o(quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_g_r[0] <= neg_f_r;
      for (int k = 1; k < Q_W; k++) neg_g_r[k] <= neg_g_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < Q_W; k++) vg_r[k] <= 1'b0;
    end else if (en) begin
      vg_r[0] <= vf_r;
      for (int k = 1; k < Q_W; k++) vg_r[k] <= vg_r[k-1];
    end
  end

  assign v_last = vg_r[Q_W-1];

  // Stage H: output register; apply signs
  logic            out_valid_r;
  out_t            out_data_r, out_data_nxt;
  logic [IN_W-1:0] q_s [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q_s[i] = neg_g_r[Q_W-1][i] ? (IN_W'(0) - IN_W'(quo[i])) : IN_W'(quo[i]);
    end
    out_data_nxt.quat_w = q_s[0];
    out_data_nxt.quat_x = q_s[1];
    out_data_nxt.quat_y = q_s[2];
    out_data_nxt.quat_z = q_s[3];
  end

  // Load the output register when it is empty or being drained; advance the
  // pipeline when the load happens or its last stage holds a bubble.
  assign load = !out_valid_r || out_ready;
  assign en   = load || !v_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= v_last;
    end
  end

  always_ff @(posedge clk) begin
    if (load && v_last) out_data_r <= out_data_nxt;
  end

  // Hold off input while reset is asserted.
  assign in_ready  = en && rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_ready && v_last) |-> !in_ready)
    else $error("input taken while pipeline is blocked");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
      v_last |-> (quo[0] <= ONE_Q && quo[1] <= ONE_Q &&
                  quo[2] <= ONE_Q && quo[3] <= ONE_Q))
    else $error("quaternion component exceeds one");

endmodule

// ----- rtl/rmq_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
module rmq_sqrt import rmq_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [RAD_W-1:0] rad_i,
  output logic [R_W-1:0]   root_o
);

  logic [RAD_W-1:0] rem_r  [R_W];
  logic [R_W-1:0]   root_r [R_W];

  for (genvar s = 0; s < R_W; s++) begin : g_stg
    localparam int I = R_W - 1 - s;
    logic [RAD_W-1:0] rem_in;
    logic [RAD_W-1:0] test;
    logic [R_W-1:0]   root_in;

    if (s == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    // (root + 2^I)^2 - root^2
    assign test = (RAD_W'(root_in) << (I + 1)) | (RAD_W'(1) << (2 * I));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= test) begin
          rem_r[s]  <= rem_in - test;
          root_r[s] <= root_in | (R_W'(1) << I);
        end else begin
          rem_r[s]  <= rem_in;
          root_r[s] <= root_in;
        end
      end
    end
  end

  assign root_o = root_r[R_W-1];

endmodule

// ----- rtl/rmq_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
module rmq_div import rmq_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dvd_i,
  input  logic [R_W-1:0]   dvs_i,
  output logic [Q_W-1:0]   quo_o
);

  logic [DVD_W-1:0] rem_r [Q_W];
  logic [R_W-1:0]   dvs_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stg
    localparam int K = Q_W - 1 - s;
    logic [DVD_W-1:0] rem_in;
    logic [DVD_W-1:0] test;
    logic [R_W-1:0]   dvs_in;
    logic [Q_W-1:0]   quo_in;

    if (s == 0) begin : g_first
      assign rem_in = dvd_i;
      assign dvs_in = dvs_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign dvs_in = dvs_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign test = DVD_W'(dvs_in) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        dvs_r[s] <= dvs_in;
        if (rem_in >= test) begin
          rem_r[s] <= rem_in - test;
          quo_r[s] <= quo_in | (Q_W'(1) << K);
        end else begin
          rem_r[s] <= rem_in;
          quo_r[s] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_r[Q_W-1];

endmodule

// ----- bench/testbench.sv -----
// Testbench for the rotation matrix to quaternion block: random and directed matrices.
`timescale 1ns / 1ps

module testbench;
  import rmq_pkg::*;

  localparam int LATENCY   = 99;
  localparam int N_RANDOM  = 530;
  localparam longint CYCLE_LIMIT = 400000;

  // Square root of a 64-bit value, truncated (bit-pair method).
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned acc;
    longint unsigned probe;
    acc = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= acc + probe) begin
        v = v - (acc + probe);
        acc = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe = probe >> 2;
    end
    return acc;
  endfunction

  // Magnitude of one component from its signed diagonal sum plus one.
  function automatic longint unsigned comp_mag(longint signed t);
    longint unsigned u;
    if (t <= 0) return 0;
    u = longint'(t);
    return root64((u << FRAC_BITS) >> 2);
  endfunction

  // Work out the unit quaternion for one matrix.
  function automatic out_t quat_of(in_t m);
    longint signed a00, a01, a02, a10, a11, a12, a20, a21, a22, one;
    longint unsigned mag [4];
    longint unsigned nrm, q;
    logic neg [4];
    logic [31:0] res [4];
    int big;
    out_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    one = 64'sd1 << FRAC_BITS;
    mag[0] = comp_mag( a00 + a11 + a22 + one);
    mag[1] = comp_mag( a00 - a11 - a22 + one);
    mag[2] = comp_mag(-a00 + a11 - a22 + one);
    mag[3] = comp_mag(-a00 - a11 + a22 + one);
    big = 0;
    for (int i = 1; i < 4; i++) if (mag[i] > mag[big]) big = i;
    for (int i = 0; i < 4; i++) neg[i] = 1'b0;
    // zero sums and differences count as non-negative
    case (big)
      0: begin
        neg[1] = (a21 - a12) < 0; neg[2] = (a02 - a20) < 0; neg[3] = (a10 - a01) < 0;
      end
      1: begin
        neg[0] = (a21 - a12) < 0; neg[2] = (a10 + a01) < 0; neg[3] = (a02 + a20) < 0;
      end
      2: begin
        neg[0] = (a02 - a20) < 0; neg[1] = (a10 + a01) < 0; neg[3] = (a21 + a12) < 0;
      end
      default: begin
        neg[0] = (a10 - a01) < 0; neg[1] = (a20 + a02) < 0; neg[2] = (a21 + a12) < 0;
      end
    endcase
    nrm = root64(mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2] + mag[3]*mag[3]);
    for (int i = 0; i < 4; i++) begin
      q = 0;
      if (nrm != 0) q = ((mag[i] << FRAC_BITS) + (nrm >> 1)) / nrm;
      if (neg[i]) q = 64'd0 - q;
      res[i] = q[31:0];
    end
    r.quat_w = res[0]; r.quat_x = res[1]; r.quat_y = res[2]; r.quat_z = res[3];
    return r;
  endfunction

  class quat_scoreboard;
    out_t pending[$];
    int   errors;

    function void note_matrix(in_t m);
      pending.push_back(quat_of(m));
    endfunction

    function void check_quat(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected quaternion %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.quat_w !== want.quat_w)
        $display("%0t: quat_w expected %h actual %h", $time, want.quat_w, got.quat_w);
      if (got.quat_x !== want.quat_x)
        $display("%0t: quat_x expected %h actual %h", $time, want.quat_x, got.quat_x);
      if (got.quat_y !== want.quat_y)
        $display("%0t: quat_y expected %h actual %h", $time, want.quat_y, got.quat_y);
      if (got.quat_z !== want.quat_z)
        $display("%0t: quat_z expected %h actual %h", $time, want.quat_z, got.quat_z);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;

  quat_scoreboard board;
  longint cycles;
  bit     hold_off;  // set while the receiver is told to stall for a long stretch

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sample accepted results at the edge; the check sees settled values.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_quat(out_data);
  end

  // Receiver: random stall per item, or a long hold when asked.
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  // Offer one matrix and hold it until accepted.
  task automatic send_matrix(in_t m, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    @(posedge clk iff in_ready);
    board.note_matrix(m);
  endtask

  // Pause the sender until every expected quaternion is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  // Near-rotation element: a random value in [-ONE, ONE].
  function automatic logic [31:0] unit_elem();
    return $urandom_range(0, 32'(64'd1 << (FRAC_BITS + 1))) - 32'(64'd1 << FRAC_BITS);
  endfunction

  // Signed permutation matrix: exercises each choice of largest component.
  function automatic in_t signed_perm(int axis, bit flip);
    in_t m;
    logic [31:0] p, n;
    p = 32'(1 << FRAC_BITS);
    n = -p;
    m = '0;
    case (axis)
      0: begin m.m00 = p; m.m11 = p; m.m22 = p; end
      1: begin m.m00 = p; m.m11 = n; m.m22 = n; end
      2: begin m.m00 = n; m.m11 = p; m.m22 = n; end
      default: begin m.m00 = n; m.m11 = n; m.m22 = p; end
    endcase
    if (flip) begin m.m01 = 32'h1000; m.m10 = -32'sh2000; m.m12 = 32'h30; m.m20 = 32'h7; end
    return m;
  endfunction

  initial begin
    in_t m;
    bit  burst;
    board    = new();
    cycles   = 0;
    hold_off = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each winning component, with and without off-diagonal signs.
    for (int a = 0; a < 4; a++) begin
      send_matrix(signed_perm(a, 1'b0), 1'b0);
      send_matrix(signed_perm(a, 1'b1), 1'b0);
    end
    // Field extremes and all-zero: non-rotation patterns, ties among magnitudes.
    m = '0;                                       send_matrix(m, 1'b0);
    m = {9{32'h7fffffff}};                        send_matrix(m, 1'b0);
    m = {9{32'h80000000}};                        send_matrix(m, 1'b0);
    m = {9{32'hffffffff}};                        send_matrix(m, 1'b0);
    m = {9{32'h00000001}};                        send_matrix(m, 1'b0);
    m = {9{32'h55555555}};                        send_matrix(m, 1'b0);
    m = {9{32'haaaaaaaa}};                        send_matrix(m, 1'b0);
    // Off-diagonal sums and differences exactly zero: sign taken as plus.
    m = signed_perm(1, 1'b0); m.m01 = 32'h100; m.m10 = -32'sh100; send_matrix(m, 1'b0);
    m = signed_perm(3, 1'b0); m.m02 = 32'h40;  m.m20 = -32'sh40;  send_matrix(m, 1'b0);
    m = signed_perm(0, 1'b0); m.m21 = 32'h10;  m.m12 = 32'h10;    send_matrix(m, 1'b0);
    // Ties between the first two magnitudes: lower index keeps positive.
    m = '0; m.m00 = 32'(1 << FRAC_BITS); m.m12 = -32'sh5; m.m21 = 32'h3; send_matrix(m, 1'b0);
    drain();

    // Fill the pipeline against a stalled receiver.
    hold_off = 1'b1;
    for (int i = 0; i < 150; i++) begin
      for (int k = 0; k < 9; k++) m[k*32 +: 32] = unit_elem();
      send_matrix(m, 1'b1);
    end
    drain();

    // Random: mostly near-rotation matrices, some raw bit patterns, bursts mixed in.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) burst = $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0)
        for (int k = 0; k < 9; k++) m[k*32 +: 32] = rand_word();
      else
        for (int k = 0; k < 9; k++) m[k*32 +: 32] = unit_elem();
      send_matrix(m, burst);
      if (i == N_RANDOM / 2) drain();
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rmq_pkg.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
bench/testbench.sv
